### hdl/isqc_pkg.sv
// Shared types, constants and the control program of the intersection queue controller.
// No dependencies; used by intersection_signal_queue_controller.
package isqc_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int NUM_QUEUES      = 8;
  localparam int QIDX_W          = $clog2(NUM_QUEUES);
  localparam int ENTRY_W         = 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GREEN_TIME   = 2'd0,
    REG_YELLOW_TIME  = 2'd1,
    REG_ALL_RED_TIME = 2'd2,
    REG_SERVICE_RATE = 2'd3
  } cfg_reg_e;

  // Reset values of the registers
  localparam logic [7:0] GREEN_TIME_RST   = 8'd8;
  localparam logic [3:0] YELLOW_TIME_RST  = 4'd2;
  localparam logic [3:0] ALL_RED_TIME_RST = 4'd1;
  localparam logic [2:0] SERVICE_RATE_RST = 3'd2;

  // Light codes
  localparam logic [1:0] LIGHT_RED    = 2'd0;
  localparam logic [1:0] LIGHT_GREEN  = 2'd1;
  localparam logic [1:0] LIGHT_YELLOW = 2'd2;

  // Input item: one tick
  typedef struct packed {
    logic [3:0] arrival_mask;
    logic [3:0] turn_mask;
  } in_item_t;

  // Result item: departure record or end-of-tick status
  typedef struct packed {
    logic        is_status;
    logic        last;
    logic [15:0] vehicle_id;
    logic [1:0]  vehicle_origin;
    logic        vehicle_turn;
    logic [15:0] wait_ticks;
    logic [1:0]  light_ns;
    logic [1:0]  light_ew;
    logic [7:0]  time_left;
    logic        active_phase;
    logic [3:0]  dropped_mask;
  } out_item_t;

  // Microcode
  localparam int UPC_W = 4;

  typedef enum logic [2:0] {
    UC_WAIT,    // take the next tick
    UC_PUSH,    // enqueue the arrival of direction arg
    UC_DECIDE,  // light sequence; jump unless green
    UC_SERVE,   // pop up to service_rate from turn queue arg of the green phase
    UC_STATUS   // emit status, advance phase state
  } uc_op_e;

  typedef struct packed {
    uc_op_e           op;
    logic [1:0]       arg;
    logic [UPC_W-1:0] jmp;
  } uc_word_t;

  localparam logic [UPC_W-1:0] UPC_START  = 4'd0;
  localparam logic [UPC_W-1:0] UPC_STATUS = 4'd10;

  // Control program, one word per step
  function automatic uc_word_t uc_rom(input logic [UPC_W-1:0] upc);
    uc_word_t w;
    w = '{op: UC_WAIT, arg: 2'd0, jmp: UPC_START};
    case (upc)
      4'd0:  w = '{op: UC_WAIT,   arg: 2'd0, jmp: UPC_START};
      4'd1:  w = '{op: UC_PUSH,   arg: 2'd0, jmp: UPC_START};
      4'd2:  w = '{op: UC_PUSH,   arg: 2'd1, jmp: UPC_START};
      4'd3:  w = '{op: UC_PUSH,   arg: 2'd2, jmp: UPC_START};
      4'd4:  w = '{op: UC_PUSH,   arg: 2'd3, jmp: UPC_START};
      4'd5:  w = '{op: UC_DECIDE, arg: 2'd0, jmp: UPC_STATUS};
      4'd6:  w = '{op: UC_SERVE,  arg: 2'd0, jmp: UPC_START};
      4'd7:  w = '{op: UC_SERVE,  arg: 2'd1, jmp: UPC_START};
      4'd8:  w = '{op: UC_SERVE,  arg: 2'd2, jmp: UPC_START};
      4'd9:  w = '{op: UC_SERVE,  arg: 2'd3, jmp: UPC_START};
      4'd10: w = '{op: UC_STATUS, arg: 2'd0, jmp: UPC_START};
      default: w = '{op: UC_WAIT, arg: 2'd0, jmp: UPC_START};
    endcase
    return w;
  endfunction

endpackage

### hdl/isqc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isqc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/intersection_signal_queue_controller.sv
// Top level of the two-phase intersection controller with eight vehicle queues.
// Depends on isqc_pkg (types, microcode) and isqc_ram (queue store).

// Each input item is one tick. A small microcoded sequencer runs it: it takes
// the item, enqueues the N/S/E/W arrivals one at a time (one write port on the
// queue store), runs the light sequence, then on green ticks serves each turn
// queue of the green phase up to service_rate vehicles, each pop being one
// registered read of the queue store, and then emits the status item. A
// stalled output holds the serve and status steps until the result is taken.
// The output register lets the next step proceed while a result waits to be
// taken. Queue entries are only read after being written, so the store needs
// no clearing after reset.
module intersection_signal_queue_controller
  import isqc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W   = QIDX_W + PTR_W;
  localparam int RAM_DEPTH = NUM_QUEUES << PTR_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Registers
  logic [7:0]       green_q, green_d;
  logic [3:0]       yellow_q, yellow_d;
  logic [3:0]       all_red_q, all_red_d;
  logic [2:0]       svc_q, svc_d;
  logic             phase_q, phase_d;
  logic [8:0]       ptick_q, ptick_d;
  logic [15:0]      tick_q, tick_d;
  logic [15:0]      next_id_q, next_id_d;
  logic [PTR_W-1:0] head_q [NUM_QUEUES];
  logic [PTR_W-1:0] head_d [NUM_QUEUES];
  logic [PTR_W-1:0] tail_q [NUM_QUEUES];
  logic [PTR_W-1:0] tail_d [NUM_QUEUES];
  logic [UPC_W-1:0] upc_q, upc_d;
  logic [3:0]       arr_q, arr_d;
  logic [3:0]       turn_q, turn_d;
  logic [3:0]       dropped_q, dropped_d;
  logic [1:0]       ns_q, ns_d;
  logic [1:0]       ew_q, ew_d;
  logic [7:0]       tleft_q, tleft_d;
  logic             change_q, change_d;
  logic [2:0]       k_q, k_d;
  logic             rd_wait_q, rd_wait_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  // Datapath signals
  uc_word_t           uw;
  logic               out_free;
  logic [QIDX_W-1:0]  qsel;
  logic [PTR_W-1:0]   head_sel;
  logic [PTR_W-1:0]   tail_sel;
  logic [8:0]         gy;
  logic [8:0]         gyr;
  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  isqc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign uw       = uc_rom(upc_q);
  assign out_free = !out_valid_q || out_ready_i;
  // Push steps pick the queue by arrival direction and turn, serve steps by green phase
  assign qsel     = (uw.op == UC_PUSH) ? {uw.arg, turn_q[uw.arg]} : {phase_q, uw.arg};
  assign head_sel = head_q[qsel];
  assign tail_sel = tail_q[qsel];
  assign gy       = {1'b0, green_q} + {5'd0, yellow_q};
  assign gyr      = gy + {5'd0, all_red_q};

  // Sequencer step
  always_comb begin
    green_d     = green_q;
    yellow_d    = yellow_q;
    all_red_d   = all_red_q;
    svc_d       = svc_q;
    phase_d     = phase_q;
    ptick_d     = ptick_q;
    tick_d      = tick_q;
    next_id_d   = next_id_q;
    head_d      = head_q;
    tail_d      = tail_q;
    upc_d       = upc_q;
    arr_d       = arr_q;
    turn_d      = turn_q;
    dropped_d   = dropped_q;
    ns_d        = ns_q;
    ew_d        = ew_q;
    tleft_d     = tleft_q;
    change_d    = change_q;
    k_d         = k_q;
    rd_wait_d   = rd_wait_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = {qsel, tail_sel};
    ram_raddr   = {qsel, head_sel};
    ram_wdata   = {tick_q, next_id_q};
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // register writes
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GREEN_TIME:   green_d   = cfg_data_i;
        REG_YELLOW_TIME:  yellow_d  = cfg_data_i[3:0];
        REG_ALL_RED_TIME: all_red_d = cfg_data_i[3:0];
        REG_SERVICE_RATE: svc_d     = cfg_data_i[2:0];
        default: ;
      endcase
    end

    case (uw.op)
      UC_WAIT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          arr_d     = in_item_i.arrival_mask;
          turn_d    = in_item_i.turn_mask;
          dropped_d = '0;
          upc_d     = upc_q + 1'b1;
        end
      end

      // One arrival: takes an id even when its queue is full
      UC_PUSH: begin
        if (arr_q[uw.arg]) begin
          next_id_d = next_id_q + 1'b1;
          if (ptr_inc(tail_sel) == head_sel) begin
            dropped_d[uw.arg] = 1'b1;
          end else begin
            ram_we       = 1'b1;
            tail_d[qsel] = ptr_inc(tail_sel);
          end
        end
        upc_d = upc_q + 1'b1;
      end

      // Light sequence: green, yellow, all red, change tick
      UC_DECIDE: begin
        ns_d     = LIGHT_RED;
        ew_d     = LIGHT_RED;
        change_d = 1'b0;
        k_d      = '0;
        upc_d    = uw.jmp;
        if (ptick_q < {1'b0, green_q}) begin
          tleft_d = green_q - ptick_q[7:0];
          if (phase_q) ew_d = LIGHT_GREEN;
          else         ns_d = LIGHT_GREEN;
          upc_d   = upc_q + 1'b1;
        end else if (ptick_q < gy) begin
          tleft_d = 8'(gy - ptick_q);
          if (phase_q) ew_d = LIGHT_YELLOW;
          else         ns_d = LIGHT_YELLOW;
        end else if (ptick_q < gyr) begin
          tleft_d = 8'(gyr - ptick_q);
        end else begin
          tleft_d  = '0;
          change_d = 1'b1;
        end
      end

      // Pop up to service_rate vehicles; a read's data lands in the cycle after it
      UC_SERVE: begin
        if (rd_wait_q && out_free) begin
          out_d                = '0;
          out_d.vehicle_id     = ram_rdata[15:0];
          out_d.vehicle_origin = {phase_q, uw.arg[1]};
          out_d.vehicle_turn   = uw.arg[0];
          out_d.wait_ticks     = tick_q - ram_rdata[31:16];
          out_valid_d          = 1'b1;
          rd_wait_d            = 1'b0;
        end
        if (!rd_wait_q || out_free) begin
          if (k_q == svc_q || head_sel == tail_sel) begin
            k_d   = '0;
            upc_d = upc_q + 1'b1;
          end else begin
            ram_re       = 1'b1;
            head_d[qsel] = ptr_inc(head_sel);
            k_d          = k_q + 1'b1;
            rd_wait_d    = 1'b1;
          end
        end
      end

      // Close the tick
      UC_STATUS: begin
        if (out_free) begin
          out_d              = '0;
          out_d.is_status    = 1'b1;
          out_d.last         = 1'b1;
          out_d.light_ns     = ns_q;
          out_d.light_ew     = ew_q;
          out_d.time_left    = tleft_q;
          out_d.active_phase = change_q ? ~phase_q : phase_q;
          out_d.dropped_mask = dropped_q;
          out_valid_d        = 1'b1;
          phase_d            = change_q ? ~phase_q : phase_q;
          ptick_d            = change_q ? '0 : ptick_q + 1'b1;
          tick_d             = tick_q + 1'b1;
          upc_d              = uw.jmp;
        end
      end

      default: upc_d = UPC_START;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      green_q     <= GREEN_TIME_RST;
      yellow_q    <= YELLOW_TIME_RST;
      all_red_q   <= ALL_RED_TIME_RST;
      svc_q       <= SERVICE_RATE_RST;
      phase_q     <= 1'b0;
      ptick_q     <= '0;
      tick_q      <= '0;
      next_id_q   <= 16'd1;
      head_q      <= '{default: '0};
      tail_q      <= '{default: '0};
      upc_q       <= UPC_START;
      k_q         <= '0;
      rd_wait_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      green_q     <= green_d;
      yellow_q    <= yellow_d;
      all_red_q   <= all_red_d;
      svc_q       <= svc_d;
      phase_q     <= phase_d;
      ptick_q     <= ptick_d;
      tick_q      <= tick_d;
      next_id_q   <= next_id_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      upc_q       <= upc_d;
      k_q         <= k_d;
      rd_wait_q   <= rd_wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Tick payload and result register
  always_ff @(posedge clk_i) begin
    arr_q     <= arr_d;
    turn_q    <= turn_d;
    dropped_q <= dropped_d;
    ns_q      <= ns_d;
    ew_q      <= ew_d;
    tleft_q   <= tleft_d;
    change_q  <= change_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
